@@ sv/ic2d_pkg.sv @@
// ic2d_pkg: shared types and constants of the streaming 2-d convolution block
`default_nettype none

package ic2d_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 24;
    localparam int SUM_W      = 29;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int POS_W      = 24;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int FR_W       = 2;
    localparam int CFG_W      = 13;
    localparam int CIDX_W     = 2;
    localparam int KIND_W     = 2;
    localparam int TAP_W      = 5;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [FR_W-1:0] RADIUS_RESET = 2'd1;

    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COEF  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [PIX_W-1:0]         pixel;
        logic [TAP_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] filtered;
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic                    frame_end;
    } out_word_t;

endpackage

`default_nettype wire

@@ sv/image_conv2d_zero_pad.sv @@
// image_conv2d_zero_pad: streaming zero-padded 2-d convolution over a line memory
//
// in_word carries pixels, flush items and coefficient writes in raster order.
// each pixel or flush word advances the stream; once radius rows and radius
// columns of history exist it yields one out_word for the lagging position,
// with its row, column and an end-of-frame mark on the last pixel of a frame.
// coefficient words and kind three produce nothing.
// after a frame the driver sends radius*width+radius flush words.
// one word is accepted per clock while in_stall is low; all stages are registered.
// the rate is set by the two-port line memory: each pixel or flush word reads one
// column of history at address t-width and writes its own column back in the
// following cycle, with forwarding when the two addresses meet.
// every stage holds when the next is full, so bubbles close up and a stalled
// result blocks input only once all stages are occupied.
// reset clears the stream position, the coefficients and all valid flags and
// loads width 1024, height 1024, radius 1; the line memory needs no clearing.
// the cfg port writes registers at any clock edge with cfg_write high.
`default_nettype none

module image_conv2d_zero_pad #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_DIM   = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire ic2d_pkg::in_word_t            in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output ic2d_pkg::out_word_t                out_word,
    input  wire logic                          cfg_write,
    input  wire logic [ic2d_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [ic2d_pkg::CFG_W-1:0]    cfg_data
);

    localparam int MAX_RADIUS = (MAX_DIM - 1) / 2;
    localparam int TAPS       = MAX_DIM * MAX_DIM;
    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int DEPTH      = 1 << AW;
    localparam int LINE_W     = ic2d_pkg::PIX_W * MAX_DIM;

    localparam int PIX_W  = ic2d_pkg::PIX_W;
    localparam int POS_W  = ic2d_pkg::POS_W;
    localparam int FW_W   = ic2d_pkg::FW_W;
    localparam int FH_W   = ic2d_pkg::FH_W;
    localparam int FR_W   = ic2d_pkg::FR_W;
    localparam int COEF_W = ic2d_pkg::COEF_W;
    localparam int PROD_W = ic2d_pkg::PROD_W;
    localparam int SUM_W  = ic2d_pkg::SUM_W;

    // configuration
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    logic [FR_W-1:0] radius_reg;
    logic [FW_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;
    logic [FR_W-1:0] r_eff;
    logic [POS_W-1:0] pixels;
    logic [POS_W-1:0] lag;
    logic [POS_W-1:0] total;

    // stream position
    logic [POS_W-1:0] t_reg, t_next, t_eff;
    logic [FH_W-1:0]  in_row_reg, in_row_next, row_in;
    logic [FW_W-1:0]  in_col_reg, in_col_next, col_in;
    logic             restart;
    logic             is_adv;
    logic             acc;
    logic             acc_adv;
    logic             ok0;
    logic             last0;
    logic [FH_W-1:0]  row_o;
    logic [FW_W-1:0]  col_o;

    // line memory
    logic [LINE_W-1:0] line_mem [DEPTH];
    logic [LINE_W-1:0] rd_reg;
    logic [LINE_W-1:0] pw_word;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     pw_addr_reg;
    logic              pw_valid_reg;
    logic              hit;

    // handshake chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, ov_reg;
    logic ld1, ld2, ld3, ld4, ld_out;

    // stage 1
    logic                      adv1_reg;
    logic                      coef1_reg;
    logic                      ok1_reg;
    logic                      last1_reg;
    logic [PIX_W-1:0]          pix1_reg;
    logic [ic2d_pkg::TAP_W-1:0] cidx1_reg;
    logic signed [COEF_W-1:0]  cval1_reg;
    logic [FH_W-1:0]           row1_reg;
    logic [FW_W-1:0]           col1_reg;

    // window and coefficients
    logic [PIX_W-1:0]         win_reg [MAX_DIM][MAX_DIM];
    logic signed [COEF_W-1:0] coef_reg [TAPS];

    // stage 2
    logic [MAX_DIM-1:0] rok_next, cok_next;
    logic [MAX_DIM-1:0] rok2_reg, cok2_reg;
    logic [FH_W-1:0]    row2_reg;
    logic [FW_W-1:0]    col2_reg;
    logic               last2_reg;

    // stage 3
    logic signed [PROD_W-1:0] prod_next [MAX_DIM][MAX_DIM];
    logic signed [PROD_W-1:0] prod3_reg [MAX_DIM][MAX_DIM];
    logic [FH_W-1:0]          row3_reg;
    logic [FW_W-1:0]          col3_reg;
    logic                     last3_reg;

    // stage 4
    logic signed [SUM_W-1:0] rsum_next [MAX_DIM];
    logic signed [SUM_W-1:0] rsum4_reg [MAX_DIM];
    logic [FH_W-1:0]         row4_reg;
    logic [FW_W-1:0]         col4_reg;
    logic                    last4_reg;

    // output
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic [FH_W-1:0]         row_out_reg;
    logic [FW_W-1:0]         col_out_reg;
    logic                    last_out_reg;

    // effective geometry
    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg == '0)
        begin
            h_eff = FH_W'(1);
        end
        else if (int'(height_reg) > ic2d_pkg::MAX_HEIGHT)
        begin
            h_eff = FH_W'(ic2d_pkg::MAX_HEIGHT);
        end
        r_eff = (int'(radius_reg) > MAX_RADIUS) ? FR_W'(MAX_RADIUS) : radius_reg;
    end

    assign pixels = POS_W'(w_eff) * POS_W'(h_eff);
    assign lag    = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);
    assign total  = pixels + lag;

    // handshake
    assign ld_out   = !ov_reg || !out_stall;
    assign ld4      = !v4_reg || ld_out;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_stall = !ld1;

    assign is_adv  = (in_word.kind == ic2d_pkg::KIND_PIXEL)
                  || (in_word.kind == ic2d_pkg::KIND_FLUSH);
    assign acc     = in_valid && ld1;
    assign acc_adv = acc && is_adv;

    // position of this word and of its output
    always_comb
    begin
        restart = (t_reg >= total);
        t_eff   = restart ? '0 : t_reg;
        row_in  = restart ? '0 : in_row_reg;
        col_in  = restart ? '0 : in_col_reg;
        ok0     = (t_eff >= lag);
        last0   = (t_eff == total - POS_W'(1));
        if (col_in >= FW_W'(r_eff))
        begin
            col_o = col_in - FW_W'(r_eff);
            row_o = row_in - FH_W'(r_eff);
        end
        else if (col_in + w_eff >= FW_W'(r_eff))
        begin
            col_o = col_in + w_eff - FW_W'(r_eff);
            row_o = row_in - FH_W'(r_eff) - FH_W'(1);
        end
        else
        begin
            // radius wider than a row: the lag crosses two rows
            col_o = col_in + w_eff + w_eff - FW_W'(r_eff);
            row_o = row_in - FH_W'(r_eff) - FH_W'(2);
        end
        if (last0)
        begin
            t_next      = '0;
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (col_in == w_eff - FW_W'(1))
        begin
            t_next      = t_eff + POS_W'(1);
            in_row_next = row_in + FH_W'(1);
            in_col_next = '0;
        end
        else
        begin
            t_next      = t_eff + POS_W'(1);
            in_row_next = row_in;
            in_col_next = col_in + FW_W'(1);
        end
    end

    // column word written back: newest pixel on top of the column read at t-width
    always_comb
    begin
        pw_word = '0;
        pw_word[PIX_W-1:0] = pix1_reg;
        for (int m = 1; m < MAX_DIM; m++)
        begin
            pw_word[m*PIX_W +: PIX_W] = rd_reg[(m-1)*PIX_W +: PIX_W];
        end
    end

    assign raddr = AW'(t_eff) - AW'(w_eff);
    assign hit   = pw_valid_reg && (pw_addr_reg == raddr);

    always_ff @(posedge clk)
    begin
        if (pw_valid_reg)
        begin
            line_mem[pw_addr_reg] <= pw_word;
        end
        if (acc)
        begin
            rd_reg <= hit ? pw_word : line_mem[raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= ic2d_pkg::WIDTH_RESET;
            height_reg   <= ic2d_pkg::HEIGHT_RESET;
            radius_reg   <= ic2d_pkg::RADIUS_RESET;
            t_reg        <= '0;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            pw_valid_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ic2d_pkg::REG_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                    ic2d_pkg::REG_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                    ic2d_pkg::REG_RADIUS: radius_reg <= cfg_data[FR_W-1:0];
                    default: ;
                endcase
            end
            if (acc_adv)
            begin
                t_reg      <= t_next;
                in_row_reg <= in_row_next;
                in_col_reg <= in_col_next;
            end
            pw_valid_reg <= acc_adv;
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg && adv1_reg && ok1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld_out)
            begin
                ov_reg <= v4_reg;
            end
            if (ld2 && v1_reg && coef1_reg)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    if (int'(cidx1_reg) == i)
                    begin
                        coef_reg[i] <= cval1_reg;
                    end
                end
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            adv1_reg    <= is_adv;
            coef1_reg   <= (in_word.kind == ic2d_pkg::KIND_COEF);
            ok1_reg     <= ok0;
            last1_reg   <= last0;
            pix1_reg    <= (in_word.kind == ic2d_pkg::KIND_PIXEL) ? in_word.pixel : '0;
            cidx1_reg   <= in_word.coef_index;
            cval1_reg   <= in_word.coef_value;
            pw_addr_reg <= AW'(t_eff);
            row1_reg    <= row_o;
            col1_reg    <= col_o;
        end
    end

    // padding masks per kernel row and column
    always_comb
    begin
        int rv;
        int cv;
        rv = 0;
        cv = 0;
        for (int k = 0; k < MAX_DIM; k++)
        begin
            rv = int'(row1_reg) + int'(r_eff) - k;
            cv = int'(col1_reg) + int'(r_eff) - k;
            rok_next[k] = (k <= 2 * int'(r_eff)) && (rv >= 0) && (rv < int'(h_eff));
            cok_next[k] = (k <= 2 * int'(r_eff)) && (cv >= 0) && (cv < int'(w_eff));
        end
    end

    // window shift and stage 2
    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg && adv1_reg)
        begin
            for (int k = 0; k < MAX_DIM; k++)
            begin
                for (int j = MAX_DIM - 1; j > 0; j--)
                begin
                    win_reg[k][j] <= win_reg[k][j-1];
                end
            end
            win_reg[0][0] <= pix1_reg;
            for (int k = 1; k < MAX_DIM; k++)
            begin
                win_reg[k][0] <= rd_reg[(k-1)*PIX_W +: PIX_W];
            end
        end
        if (ld2)
        begin
            rok2_reg  <= rok_next;
            cok2_reg  <= cok_next;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            last2_reg <= last1_reg;
        end
    end

    // products
    always_comb
    begin
        logic [PIX_W-1:0]         px;
        logic signed [COEF_W-1:0] c;
        px = '0;
        c  = '0;
        for (int k = 0; k < MAX_DIM; k++)
        begin
            for (int j = 0; j < MAX_DIM; j++)
            begin
                px = (rok2_reg[k] && cok2_reg[j]) ? win_reg[k][j] : '0;
                c  = '0;
                for (int rr = 0; rr <= MAX_RADIUS; rr++)
                begin
                    if ((int'(r_eff) == rr) && (k <= 2 * rr) && (j <= 2 * rr))
                    begin
                        c = coef_reg[(2 * rr - k) * MAX_DIM + (2 * rr - j)];
                    end
                end
                prod_next[k][j] = PROD_W'(c * $signed({1'b0, px}));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            prod3_reg <= prod_next;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            last3_reg <= last2_reg;
        end
    end

    // row sums
    always_comb
    begin
        for (int k = 0; k < MAX_DIM; k++)
        begin
            rsum_next[k] = '0;
            for (int j = 0; j < MAX_DIM; j++)
            begin
                rsum_next[k] = rsum_next[k] + SUM_W'(prod3_reg[k][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            rsum4_reg <= rsum_next;
            row4_reg  <= row3_reg;
            col4_reg  <= col3_reg;
            last4_reg <= last3_reg;
        end
    end

    // final sum
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < MAX_DIM; k++)
        begin
            sum_next = sum_next + rsum4_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            sum_reg      <= sum_next;
            row_out_reg  <= row4_reg;
            col_out_reg  <= col4_reg;
            last_out_reg <= last4_reg;
        end
    end

    assign out_valid          = ov_reg;
    assign out_word.filtered  = sum_reg;
    assign out_word.out_row   = row_out_reg[ic2d_pkg::ROW_W-1:0];
    assign out_word.out_col   = col_out_reg[ic2d_pkg::COL_W-1:0];
    assign out_word.frame_end = last_out_reg;

`ifndef ASSERT_OFF
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    a_writeback_follows: assert property (@(posedge clk) disable iff (!rst_n)
        acc_adv |=> pw_valid_reg)
        else $error("line memory write-back missing after stream word");

    a_s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v2_reg) |-> $past(v1_reg && adv1_reg && ok1_reg))
        else $error("stage 2 filled without an output-bearing word");

    a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v4_reg))
        else $error("result shown without a summed word");
`endif

endmodule

`default_nettype wire

@@ dv/image_conv2d_zero_pad_test.sv @@
// testbench for the streaming zero-padded 2-d convolution block
`default_nettype none

module image_conv2d_zero_pad_test;

    localparam int MAXW = 1024;
    localparam int NDIM = 5;
    localparam int NTAP = NDIM * NDIM;
    localparam int LDEPTH = (NDIM - 1) * MAXW + NDIM;
    localparam int WDOG = 20000;
    localparam int CFGW = ic2d_pkg::CFG_W;
    localparam int KINDW = ic2d_pkg::KIND_W;

    class conv_scoreboard;
        int unsigned width_reg, height_reg, radius_reg;
        logic [7:0] history [LDEPTH];
        logic signed [15:0] coefs [NTAP];
        int unsigned position;
        ic2d_pkg::out_word_t pending [$];
        int errors;

        function void clear();
            width_reg = 1024;
            height_reg = 1024;
            radius_reg = 1;
            position = 0;
            errors = 0;
            foreach (history[i]) history[i] = 0;
            foreach (coefs[i]) coefs[i] = 0;
            pending.delete();
        endfunction

        function void set_reg(logic [ic2d_pkg::CIDX_W-1:0] idx,
                              logic [ic2d_pkg::CFG_W-1:0] val);
            if (idx == ic2d_pkg::REG_WIDTH) width_reg = val[ic2d_pkg::FW_W-1:0];
            else if (idx == ic2d_pkg::REG_HEIGHT) height_reg = val[ic2d_pkg::FH_W-1:0];
            else if (idx == ic2d_pkg::REG_RADIUS) radius_reg = val[ic2d_pkg::FR_W-1:0];
        endfunction

        function void note_input(ic2d_pkg::in_word_t w);
            int unsigned fw, fh, rad, pixels, lag, total, t, q, row, col;
            int rr, cc;
            logic signed [31:0] acc;
            ic2d_pkg::out_word_t o;
            if (w.kind == ic2d_pkg::KIND_COEF)
            begin
                if (w.coef_index < NTAP) coefs[w.coef_index] = w.coef_value;
                return;
            end
            if (w.kind != ic2d_pkg::KIND_PIXEL && w.kind != ic2d_pkg::KIND_FLUSH) return;
            fw = width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
            fh = height_reg < 1 ? 1 : (height_reg > 4096 ? 4096 : height_reg);
            rad = radius_reg > 2 ? 2 : radius_reg;
            pixels = fw * fh;
            lag = rad * fw + rad;
            total = pixels + lag;
            t = position >= total ? 0 : position;
            history[t % LDEPTH] = (w.kind == ic2d_pkg::KIND_PIXEL) ? w.pixel : 8'd0;
            position = (t + 1 >= total) ? 0 : t + 1;
            if (t < lag) return;
            q = t - lag;
            if (q >= pixels) return;
            row = q / fw;
            col = q % fw;
            acc = 0;
            for (int dy = -int'(rad); dy <= int'(rad); dy++)
                for (int dx = -int'(rad); dx <= int'(rad); dx++)
                begin
                    rr = int'(row) + dy;
                    cc = int'(col) + dx;
                    if (rr >= 0 && rr < int'(fh) && cc >= 0 && cc < int'(fw))
                        acc += int'(coefs[(dy + rad) * NDIM + dx + rad])
                            * int'({1'b0, history[(rr * fw + cc) % LDEPTH]});
                end
            o.filtered = acc[ic2d_pkg::SUM_W-1:0];
            o.out_row = row[ic2d_pkg::ROW_W-1:0];
            o.out_col = col[ic2d_pkg::COL_W-1:0];
            o.frame_end = (q == pixels - 1);
            pending.push_back(o);
        endfunction

        function void check_result(ic2d_pkg::out_word_t got);
            ic2d_pkg::out_word_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.filtered !== e.filtered)
            begin
                $error("filtered exp %0d got %0d", e.filtered, got.filtered);
                errors++;
            end
            if (got.out_row !== e.out_row)
            begin
                $error("out_row exp %0d got %0d", e.out_row, got.out_row);
                errors++;
            end
            if (got.out_col !== e.out_col)
            begin
                $error("out_col exp %0d got %0d", e.out_col, got.out_col);
                errors++;
            end
            if (got.frame_end !== e.frame_end)
            begin
                $error("frame_end exp %0d got %0d", e.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    ic2d_pkg::in_word_t in_word;
    ic2d_pkg::out_word_t out_word;
    logic cfg_write;
    logic [ic2d_pkg::CIDX_W-1:0] cfg_index;
    logic [ic2d_pkg::CFG_W-1:0] cfg_data;

    conv_scoreboard board;
    bit quiet;
    int idle_cycles;
    int fw_now, fh_now, rad_now;

    image_conv2d_zero_pad u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) board.note_input(in_word);
            if (out_valid && !out_stall) board.check_result(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send_word(ic2d_pkg::in_word_t w);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_kind(logic [ic2d_pkg::KIND_W-1:0] k, logic [7:0] p);
        ic2d_pkg::in_word_t w;
        w.kind = k;
        w.pixel = p;
        w.coef_index = 5'($urandom);
        w.coef_value = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_coef(logic [4:0] idx, logic [15:0] val);
        ic2d_pkg::in_word_t w;
        w.kind = ic2d_pkg::KIND_COEF;
        w.pixel = 8'($urandom);
        w.coef_index = idx;
        w.coef_value = val;
        send_word(w);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(logic [ic2d_pkg::CIDX_W-1:0] idx,
                             logic [ic2d_pkg::CFG_W-1:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_write <= 0;
    endtask

    task automatic setup(int fw, int fh, int rad);
        drain();
        write_reg(ic2d_pkg::REG_WIDTH, CFGW'(fw));
        write_reg(ic2d_pkg::REG_HEIGHT, CFGW'(fh));
        write_reg(ic2d_pkg::REG_RADIUS, CFGW'(rad));
        fw_now = fw;
        fh_now = fh;
        rad_now = rad;
    endtask

    task automatic load_kernel(bit extremes);
        for (int i = 0; i < NTAP; i++)
            send_coef(5'(i), extremes ? ((i % 2) ? 16'h8000 : 16'h7fff) : 16'($urandom));
    endtask

    // one frame of random pixels plus flush tail, occasionally broken
    task automatic send_frame(bit broken);
        int fwc, fhc, radc, n, lag, done;
        logic [ic2d_pkg::KIND_W-1:0] k;
        fwc = fw_now < 1 ? 1 : (fw_now > MAXW ? MAXW : fw_now);
        fhc = fh_now < 1 ? 1 : (fh_now > 4096 ? 4096 : fh_now);
        radc = rad_now > 2 ? 2 : rad_now;
        n = fwc * fhc;
        lag = radc * fwc + radc;
        done = 0;
        while (done < n)
        begin
            k = ic2d_pkg::KIND_PIXEL;
            if (broken && $urandom_range(0, 9) == 0) k = KINDW'($urandom_range(0, 3));
            send_kind(k, 8'($urandom));
            if (k == ic2d_pkg::KIND_PIXEL || k == ic2d_pkg::KIND_FLUSH) done++;
        end
        for (int i = 0; i < lag; i++)
            send_kind(($urandom_range(0, 9) == 0) ? ic2d_pkg::KIND_PIXEL : ic2d_pkg::KIND_FLUSH,
                      8'($urandom));
    endtask

    initial
    begin
        int sent;
        board = new();
        board.clear();
        quiet = 0;
        idle_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        in_word = '0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extreme kernel, pixel extremes, odd kinds, bad tap index
        setup(3, 2, 1);
        load_kernel(1);
        send_coef(5'd31, 16'h1234);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'hff);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'h00);
        send_kind(2'd3, 8'h55);
        send_kind(ic2d_pkg::KIND_FLUSH, 8'h00);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'hff);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'hff);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'haa);
        for (int i = 0; i < 4; i++) send_kind(ic2d_pkg::KIND_FLUSH, 8'hff);

        // out-of-range register values
        setup(0, 0, 3);
        send_frame(0);
        // partial frames, then a tiny frame that restarts the stream
        setup(2047, 1, 0);
        for (int i = 0; i < 6; i++) send_kind(ic2d_pkg::KIND_PIXEL, 8'($urandom));
        setup(1, 1, 0);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'($urandom));
        setup(4, 8191, 2);
        for (int i = 0; i < 14; i++) send_kind(ic2d_pkg::KIND_PIXEL, 8'($urandom));
        setup(1, 1, 0);
        send_kind(ic2d_pkg::KIND_PIXEL, 8'($urandom));

        sent = 0;
        while (sent < 400)
        begin
            setup($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) load_kernel(0);
            send_frame($urandom_range(0, 4) == 0);
            sent += fw_now * fh_now;
            if (sent > 320) quiet = 1;
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
sv/ic2d_pkg.sv
sv/image_conv2d_zero_pad.sv
dv/image_conv2d_zero_pad_test.sv
